// File: src/grid_max_path_sum_macros.svh
// Assertion macros shared by the grid path-sum RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef GRID_MAX_PATH_SUM_MACROS_SVH
`define GRID_MAX_PATH_SUM_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication: when ante holds, cons must hold at that edge.
`define GMPS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("grid_max_path_sum: same-cycle check failed");
// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define GMPS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("grid_max_path_sum: next-cycle check failed");
`else
`define GMPS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define GMPS_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: src/gmps_pkg.sv
// Shared types and constants for the grid path-sum block.
// No dependencies; used by the interfaces and every module except gmps_ram.
package gmps_pkg;

  localparam int SUM_BITS   = 32;
  localparam int VALUE_BITS = 18;
  localparam int COLS_BITS  = 11;

  // Best sum into a cell plus its reachable flag.
  typedef struct packed {
    logic                       ok;
    logic signed [SUM_BITS-1:0] sum;
  } sum_t;

  localparam sum_t SUM_NONE = '{ok: 1'b0, sum: '0};

  // Per-cell control for the datapath: which neighbors count and the cell itself.
  typedef struct packed {
    logic                         top_left;
    logic                         has_left;
    logic                         has_up;
    logic                         blocked;
    logic signed [VALUE_BITS-1:0] value;
  } cell_ctl_t;

endpackage

// File: src/gmps_cell_if.sv
// Input channel carrying one grid cell per item.
// Depends on gmps_pkg for field widths.
interface gmps_cell_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [gmps_pkg::VALUE_BITS-1:0] cell_value;
  logic                                  cell_blocked;
  logic                                  grid_start;

  modport source (output valid, output cell_value, output cell_blocked, output grid_start,
                  input ready);
  modport sink (input valid, input cell_value, input cell_blocked, input grid_start,
                output ready);
endinterface

// File: src/gmps_result_if.sv
// Output channel carrying one path-sum result per item.
// Depends on gmps_pkg for field widths.
interface gmps_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [gmps_pkg::SUM_BITS-1:0] path_sum;
  logic                                reachable;
  logic                                row_end;

  modport source (output valid, output path_sum, output reachable, output row_end,
                  input ready);
  modport sink (input valid, input path_sum, input reachable, input row_end,
                output ready);
endinterface

// File: src/gmps_cfg_if.sv
// Configuration write channel for the column count register.
// Depends on gmps_pkg for the register width.
interface gmps_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [gmps_pkg::COLS_BITS-1:0]   data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/gmps_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module gmps_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 1024
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/gmps_cell.sv
// Per-cell datapath: best of the reachable neighbors plus the cell value, saturated.
// Depends on gmps_pkg for sum_t and cell_ctl_t.
module gmps_cell (
  input  gmps_pkg::cell_ctl_t ctl,
  input  gmps_pkg::sum_t      left,
  input  gmps_pkg::sum_t      up,
  input  gmps_pkg::sum_t      diag,
  output gmps_pkg::sum_t      res
);

  localparam int WIDE = gmps_pkg::SUM_BITS + 1;
  localparam logic signed [gmps_pkg::SUM_BITS-1:0] SUM_MIN =
    {1'b1, {(gmps_pkg::SUM_BITS-1){1'b0}}};
  localparam logic signed [gmps_pkg::SUM_BITS-1:0] SUM_MAX =
    {1'b0, {(gmps_pkg::SUM_BITS-1){1'b1}}};

  gmps_pkg::sum_t         best;
  logic signed [WIDE-1:0] wide;

  // Pick the largest reachable predecessor; the top-left cell starts a path at zero.
  always_comb begin
    best = gmps_pkg::SUM_NONE;
    if (ctl.top_left) begin
      best.ok = 1'b1;
    end else begin
      if (ctl.has_left && left.ok) begin
        best = left;
      end
      if (ctl.has_up && up.ok && (!best.ok || up.sum > best.sum)) begin
        best = up;
      end
      if (ctl.has_up && ctl.has_left && diag.ok && (!best.ok || diag.sum > best.sum)) begin
        best = diag;
      end
    end
  end

  // Add the cell value with one guard bit and clamp on overflow.
  assign wide = WIDE'(best.sum) + WIDE'(ctl.value);

  always_comb begin
    res = gmps_pkg::SUM_NONE;
    if (!ctl.blocked && best.ok) begin
      res.ok = 1'b1;
      if (wide[WIDE-1] != wide[WIDE-2]) begin
        res.sum = wide[WIDE-1] ? SUM_MIN : SUM_MAX;
      end else begin
        res.sum = wide[WIDE-2:0];
      end
    end
  end

endmodule

// File: src/grid_max_path_sum.sv
// Pipeline: an accepted item loads the cell register (s0), and its result then loads the
// output register, from which the result item can be taken.
// Throughput: one item per cycle while the result side is ready; the row-buffer read is issued at accept and a
// same-column write in that cycle is forwarded, so the output register alone sets the pace.
// Reset (synchronous, rst high): empty pipeline, column 0, first row, column count 1.
// The row buffer is not cleared; first-row cells never use what it returns.
`include "grid_max_path_sum_macros.svh"
module grid_max_path_sum #(
  parameter int MAX_COLS = 1024
) (
  input logic           clk,
  input logic           rst,
  gmps_cell_if.sink     cells,
  gmps_result_if.source sums,
  gmps_cfg_if.sink      cfg
);

  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  // Configuration and column tracking.
  logic [gmps_pkg::COLS_BITS-1:0] num_columns;
  logic [COL_W-1:0]               column_index;
  logic                           in_first_row;

  // Cell register between accept and compute.
  logic                                  s0_valid;
  logic [COL_W-1:0]                      s0_col;
  logic                                  s0_first;
  logic                                  s0_row_end;
  logic                                  s0_blocked;
  logic signed [gmps_pkg::VALUE_BITS-1:0] s0_value;

  // Neighbor state, forwarding and output register.
  gmps_pkg::sum_t                        left_sum;
  gmps_pkg::sum_t                        diag_sum;
  gmps_pkg::sum_t                        fwd_data;
  logic                                  fwd_hit;
  logic                                  out_valid;
  logic signed [gmps_pkg::SUM_BITS-1:0]  out_sum;
  logic                                  out_reach;
  logic                                  out_row_end;

  logic                                  acc;
  logic                                  s0_adv;
  logic [COL_W-1:0]                      acc_col;
  logic                                  acc_first;
  logic                                  acc_row_end;
  logic [$bits(gmps_pkg::sum_t)-1:0]     rd_data;
  gmps_pkg::sum_t                        up_sum;
  gmps_pkg::sum_t                        res;
  gmps_pkg::cell_ctl_t                   ctl;

  // Handshakes.
  assign cfg.ready   = 1'b1;
  assign s0_adv      = s0_valid && (!out_valid || sums.ready);
  assign cells.ready = !s0_valid || s0_adv;
  assign acc         = cells.valid && cells.ready;

  // Column and row position of the item being accepted.
  assign acc_col     = cells.grid_start ? '0 : column_index;
  assign acc_first   = cells.grid_start || in_first_row;
  assign acc_row_end = (32'(acc_col) + 32'd1 >= 32'(num_columns)) ||
                       (32'(acc_col) + 32'd1 >= 32'(MAX_COLS));

  // Column count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_columns <= gmps_pkg::COLS_BITS'(1);
    end else if (cfg.valid) begin
      num_columns <= cfg.data;
    end
  end

  // Column counter and first-row flag advance on every accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      in_first_row <= 1'b1;
    end else if (acc) begin
      column_index <= acc_row_end ? '0 : COL_W'(32'(acc_col) + 32'd1);
      in_first_row <= acc_row_end ? 1'b0 : acc_first;
    end
  end

  // Pipeline valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (acc) begin
        s0_valid <= 1'b1;
      end else if (s0_adv) begin
        s0_valid <= 1'b0;
      end
      if (s0_adv) begin
        out_valid <= 1'b1;
      end else if (sums.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Cell register payload and write-to-read forwarding for the row buffer.
  always_ff @(posedge clk) begin
    if (acc) begin
      s0_col     <= acc_col;
      s0_first   <= acc_first;
      s0_row_end <= acc_row_end;
      s0_blocked <= cells.cell_blocked;
      s0_value   <= cells.cell_value;
      fwd_hit    <= s0_adv && (s0_col == acc_col);
      fwd_data   <= res;
    end
  end

  // Row buffer of the previous row's results, one entry per column.
  gmps_ram #(
    .WIDTH ($bits(gmps_pkg::sum_t)),
    .DEPTH (MAX_COLS)
  ) u_row_buf (
    .clk     (clk),
    .wr_en   (s0_adv),
    .wr_addr (s0_col),
    .wr_data (res),
    .rd_en   (acc),
    .rd_addr (acc_col),
    .rd_data (rd_data)
  );

  assign up_sum = fwd_hit ? fwd_data : gmps_pkg::sum_t'(rd_data);

  // Cell datapath.
  always_comb begin
    ctl.top_left = s0_first && (s0_col == '0);
    ctl.has_left = (s0_col != '0);
    ctl.has_up   = !s0_first;
    ctl.blocked  = s0_blocked;
    ctl.value    = s0_value;
  end

  gmps_cell u_cell (
    .ctl  (ctl),
    .left (left_sum),
    .up   (up_sum),
    .diag (diag_sum),
    .res  (res)
  );

  // Left and diagonal neighbors for the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_sum <= gmps_pkg::SUM_NONE;
      diag_sum <= gmps_pkg::SUM_NONE;
    end else if (s0_adv) begin
      left_sum <= res;
      diag_sum <= up_sum;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (s0_adv) begin
      out_sum     <= res.sum;
      out_reach   <= res.ok;
      out_row_end <= s0_row_end;
    end
  end

  assign sums.valid     = out_valid;
  assign sums.path_sum  = out_sum;
  assign sums.reachable = out_reach;
  assign sums.row_end   = out_row_end;

  // Checks on the pipeline and column tracking.
  `GMPS_ASSERT_NXT(a_s0_hold, clk, rst, s0_valid && !s0_adv, s0_valid && $stable(s0_col))
  `GMPS_ASSERT_IMP(a_unreach_zero, clk, rst, out_valid && !out_reach, out_sum == '0)
  `GMPS_ASSERT_NXT(a_start_top_left, clk, rst, acc && cells.grid_start, s0_first && s0_col == '0)
  `GMPS_ASSERT_NXT(a_row_wrap, clk, rst, acc && acc_row_end, column_index == '0 && !in_first_row)
  `GMPS_ASSERT_IMP(a_col_range, clk, rst, 1'b1, 32'(column_index) < 32'(MAX_COLS))

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for grid_max_path_sum: streams grids of cells, predicts each
// best path sum in a behavioral model and checks every result item. Depends on gmps_pkg
// and the gmps_cell_if, gmps_result_if and gmps_cfg_if interfaces.
module testbench;

  localparam int SUM_BITS   = gmps_pkg::SUM_BITS;
  localparam int VALUE_BITS = gmps_pkg::VALUE_BITS;
  localparam int COLS_BITS  = gmps_pkg::COLS_BITS;
  localparam int MAX_COLS = 1024;
  localparam longint SUM_HI = (longint'(1) <<< (SUM_BITS - 1)) - 1;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  typedef struct packed {
    logic signed [SUM_BITS-1:0] path_sum;
    logic                       reachable;
    logic                       row_end;
  } path_result_t;

  logic clk;
  logic rst;

  gmps_cell_if   cell_bus ();
  gmps_result_if sum_bus ();
  gmps_cfg_if    cfg_bus ();

  grid_max_path_sum #(.MAX_COLS(MAX_COLS)) u_top (
    .clk   (clk),
    .rst   (rst),
    .cells (cell_bus),
    .sums  (sum_bus),
    .cfg   (cfg_bus)
  );

  // Predicted grid state: previous row, left and up-left neighbors, position, column count.
  gmps_pkg::sum_t       prev_row [MAX_COLS];
  bit                   row_written [MAX_COLS];
  gmps_pkg::sum_t       left_nb = gmps_pkg::SUM_NONE;
  gmps_pkg::sum_t       diag_nb = gmps_pkg::SUM_NONE;
  int unsigned          col_idx = 0;
  bit                   first_row = 1'b1;
  logic [COLS_BITS-1:0] cols_reg = COLS_BITS'(1);

  path_result_t expected_sums[$];
  int           mismatch_count = 0;
  int           src_idle_pct = 32;
  int           sink_stall_pct = 32;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Effective row width: zero acts as one, anything above the row buffer is clamped.
  function automatic int unsigned row_width();
    if (cols_reg == 0) return 1;
    if (cols_reg > MAX_COLS) return MAX_COLS;
    return 32'(cols_reg);
  endfunction

  function automatic gmps_pkg::sum_t better_of(gmps_pkg::sum_t best, gmps_pkg::sum_t cand);
    if (cand.ok && (!best.ok || cand.sum > best.sum)) return cand;
    return best;
  endfunction

  // Advance the predicted grid by one cell and return the result it should produce.
  function automatic path_result_t predict_path_sum(logic signed [VALUE_BITS-1:0] value,
                                                    bit blocked, bit start);
    int unsigned    cols;
    int unsigned    j;
    gmps_pkg::sum_t up;
    gmps_pkg::sum_t best;
    gmps_pkg::sum_t res;
    longint         total;
    path_result_t   r;
    cols = row_width();
    if (start) begin
      col_idx = 0;
      first_row = 1'b1;
    end
    if (col_idx >= MAX_COLS) col_idx = MAX_COLS - 1;
    j = col_idx;
    up = prev_row[j];
    best = gmps_pkg::SUM_NONE;
    if (first_row && j == 0) begin
      best.ok = 1'b1;
    end else begin
      if (j > 0) best = better_of(best, left_nb);
      if (!first_row) begin
        best = better_of(best, up);
        if (j > 0) best = better_of(best, diag_nb);
      end
    end
    res = gmps_pkg::SUM_NONE;
    if (!blocked && best.ok) begin
      total = longint'(best.sum) + longint'(value);
      if (total > SUM_HI) total = SUM_HI;
      else if (total < SUM_LO) total = SUM_LO;
      res.ok = 1'b1;
      res.sum = total[SUM_BITS-1:0];
    end
    prev_row[j] = res;
    row_written[j] = 1'b1;
    diag_nb = up;
    left_nb = res;
    r.row_end = (j + 1 >= cols);
    if (r.row_end) begin
      col_idx = 0;
      first_row = 1'b0;
    end else begin
      col_idx = j + 1;
    end
    r.path_sum = res.sum;
    r.reachable = res.ok;
    return r;
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] random_value();
    case ($urandom_range(9))
      0: return VALUE_MAX;
      1: return VALUE_MIN;
      2: return VALUE_BITS'(int'($urandom_range(16)) - 8);
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  // Send one cell item and record its expected result once it is accepted. A cell that
  // would read a row-buffer entry never written since reset starts a new grid instead.
  task automatic send_cell(input logic signed [VALUE_BITS-1:0] value, input bit blocked,
                           input bit start);
    bit begin_grid;
    begin_grid = start || (!first_row && !row_written[col_idx]);
    while ($urandom_range(99) < src_idle_pct) begin
      cell_bus.valid <= 1'b0;
      @(posedge clk);
    end
    cell_bus.valid        <= 1'b1;
    cell_bus.cell_value   <= value;
    cell_bus.cell_blocked <= blocked;
    cell_bus.grid_start   <= begin_grid;
    do @(posedge clk); while (!cell_bus.ready);
    expected_sums.push_back(predict_path_sum(value, blocked, begin_grid));
  endtask

  // Change the column count once the block has drained every outstanding item.
  task automatic write_columns(input int count);
    cell_bus.valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= COLS_BITS'(count);
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    cols_reg = COLS_BITS'(count);
  endtask

  // The first cell after reset is the top-left even without a grid start, at the reset
  // column count of one.
  task automatic test_reset_start();
    send_cell(VALUE_MAX, 1'b0, 1'b0);
    send_cell(VALUE_MIN, 1'b0, 1'b0);
    send_cell(18'sd5, 1'b1, 1'b0);
    send_cell(18'sd7, 1'b0, 1'b0);
    send_cell(-18'sd1, 1'b0, 1'b1);
  endtask

  // A blocked top-left cell leaves the whole grid unreachable.
  task automatic test_blocked_top_left();
    write_columns(3);
    send_cell(18'sd9, 1'b1, 1'b1);
    for (int i = 0; i < 8; i++) send_cell(VALUE_BITS'(100 + i), 1'b0, 1'b0);
    send_cell(18'sd2, 1'b0, 1'b1);
    send_cell(18'sd3, 1'b0, 1'b0);
  endtask

  // A column count of zero behaves as one.
  task automatic test_column_count_zero();
    write_columns(0);
    send_cell(18'sd4, 1'b0, 1'b1);
    send_cell(-18'sd6, 1'b0, 1'b0);
    send_cell(18'sd8, 1'b0, 1'b0);
    write_columns(1);
    send_cell(18'sd1, 1'b0, 1'b0);
  endtask

  // Shrinking the row mid-row ends it at once; growing it inside the first row just
  // lengthens that row.
  task automatic test_columns_changed_mid_row();
    write_columns(6);
    send_cell(18'sd10, 1'b0, 1'b1);
    for (int i = 0; i < 3; i++) send_cell(VALUE_BITS'(20 + i), 1'b0, 1'b0);
    write_columns(2);
    send_cell(18'sd30, 1'b0, 1'b0);
    send_cell(-18'sd5, 1'b0, 1'b0);
    send_cell(18'sd7, 1'b0, 1'b0);
    write_columns(3);
    for (int i = 0; i < 3; i++) send_cell(VALUE_BITS'(11 * i), 1'b0, 1'b0);
    write_columns(3);
    send_cell(18'sd1, 1'b0, 1'b1);
    send_cell(18'sd2, 1'b0, 1'b0);
    write_columns(5);
    for (int i = 0; i < 8; i++) send_cell(random_value(), 1'b0, 1'b0);
  endtask

  // The largest column count is clamped to the row buffer; moving to exactly the buffer
  // width inside that row keeps the row running.
  task automatic test_wide_rows();
    write_columns((1 << COLS_BITS) - 1);
    send_cell(random_value(), 1'b0, 1'b1);
    for (int i = 1; i < 24; i++)
      send_cell(random_value(), $urandom_range(19) == 0, 1'b0);
    write_columns(MAX_COLS);
    for (int i = 0; i < 8; i++) send_cell(random_value(), 1'b0, 1'b0);
  endtask

  // Whole grids with random content and obstacles, with occasional stray grid starts and
  // grids that run on without one. The opening stretch runs without any idling.
  task automatic test_random_grids();
    int sent;
    int ncells;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    sent = 0;
    while (sent < 960) begin
      if (sent >= 300) begin
        src_idle_pct = 32;
        sink_stall_pct = 32;
      end
      if (sent == 0 || $urandom_range(1) == 1) begin
        case ($urandom_range(19))
          0:       write_columns(0);
          1, 2:    write_columns($urandom_range(13, 40));
          default: write_columns($urandom_range(1, 12));
        endcase
      end
      ncells = $urandom_range(1, 6) * row_width();
      for (int i = 0; i < ncells; i++) begin
        send_cell(random_value(), $urandom_range(99) < 12,
                  (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(99) == 0));
        sent++;
      end
    end
  endtask

  // Result side stalls at random.
  initial begin
    sum_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      sum_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Compare every accepted result item with the oldest expected one.
  always @(posedge clk) begin : check_results
    path_result_t want;
    path_result_t got;
    if (!rst && sum_bus.valid && sum_bus.ready) begin
      got.path_sum = sum_bus.path_sum;
      got.reachable = sum_bus.reachable;
      got.row_end = sum_bus.row_end;
      if (expected_sums.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result item: sum %0d reachable %0b row_end %0b",
                   got.path_sum, got.reachable, got.row_end);
      end else begin
        want = expected_sums.pop_front();
        if (got.path_sum !== want.path_sum || got.reachable !== want.reachable ||
            got.row_end !== want.row_end) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected sum %0d reachable %0b row_end %0b, got %0d %0b %0b",
                     want.path_sum, want.reachable, want.row_end,
                     got.path_sum, got.reachable, got.row_end);
        end
      end
    end
  end

  initial begin
    #8ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int waited;
    rst                   <= 1'b1;
    cell_bus.valid        <= 1'b0;
    cell_bus.cell_value   <= '0;
    cell_bus.cell_blocked <= 1'b0;
    cell_bus.grid_start   <= 1'b0;
    cfg_bus.valid         <= 1'b0;
    cfg_bus.data          <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_reset_start();
    test_blocked_top_left();
    test_column_count_zero();
    test_columns_changed_mid_row();
    test_wide_rows();
    test_random_grids();

    // Drain, then keep clocking so that any stray item can show.
    cell_bus.valid <= 1'b0;
    for (waited = 0; waited < 20000 && expected_sums.size() != 0; waited++)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_sums.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: grid_max_path_sum.f
+incdir+src
src/gmps_pkg.sv
src/gmps_cell_if.sv
src/gmps_result_if.sv
src/gmps_cfg_if.sv
src/gmps_ram.sv
src/gmps_cell.sv
src/grid_max_path_sum.sv
bench/testbench.sv
